### hdl/aggtg_pkg.sv
// Package with types and constants for the Ackermann go-to-goal controller.
`timescale 1ns / 1ps
package aggtg_pkg;

  localparam int AtanEntries = 24;
  localparam logic signed [15:0] PiQ13     = 16'sd25736;
  localparam logic signed [17:0] TwoPiQ13  = 18'sd51472;
  localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;
  localparam logic signed [31:0] HalfPiQ16 = 32'sd102944;
  localparam logic [15:0] InvGainQ16 = 16'd39797;
  localparam logic [15:0] OneMetreQ12 = 16'd4096;

  localparam logic [1:0] RegGoalTol  = 2'd0;
  localparam logic [1:0] RegMaxSpeed = 2'd1;
  localparam logic [1:0] RegMinSpeed = 2'd2;
  localparam logic [1:0] RegMaxSteer = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_ITER,
    ST_MAG,
    ST_POST,
    ST_SCALE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic step;
  } cordic_ctl_t;

  function automatic logic [16:0] atan_q16(input logic [4:0] i);
    logic [16:0] v;
    begin
      case (i)
        5'd0: v = 17'd51472;
        5'd1: v = 17'd30386;
        5'd2: v = 17'd16055;
        5'd3: v = 17'd8150;
        5'd4: v = 17'd4091;
        5'd5: v = 17'd2047;
        5'd6: v = 17'd1024;
        5'd7: v = 17'd512;
        5'd8: v = 17'd256;
        5'd9: v = 17'd128;
        5'd10: v = 17'd64;
        5'd11: v = 17'd32;
        5'd12: v = 17'd16;
        5'd13: v = 17'd8;
        5'd14: v = 17'd4;
        5'd15: v = 17'd2;
        5'd16: v = 17'd1;
        default: v = 17'd0;
      endcase
      return v;
    end
  endfunction

endpackage

### hdl/aggtg_cordic.sv
// Iterative CORDIC vectoring unit, one micro-rotation per cycle.
`timescale 1ns / 1ps
module aggtg_cordic
  import aggtg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cordic_ctl_t         ctl,
  input  logic [4:0]          iter,
  input  logic signed [24:0]  dx,
  input  logic signed [24:0]  dy,
  output logic signed [27:0]  x_q,
  output logic signed [31:0]  z_q
);

  logic signed [27:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [31:0] z_r, z_nxt;
  logic signed [27:0] xs, ys;

  assign xs = x_r >>> iter;
  assign ys = y_r >>> iter;

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (ctl.start) begin
      if (dx < 0) begin
        if (dy >= 0) begin
          x_nxt = 28'(dy);
          y_nxt = -28'(dx);
          z_nxt = HalfPiQ16;
        end else begin
          x_nxt = -28'(dy);
          y_nxt = 28'(dx);
          z_nxt = -HalfPiQ16;
        end
      end else begin
        x_nxt = 28'(dx);
        y_nxt = 28'(dy);
        z_nxt = '0;
      end
    end else if (ctl.step) begin
      if (y_r > 0) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + 32'(atan_q16(iter));
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - 32'(atan_q16(iter));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
      z_r <= '0;
    end else begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_q = x_r;
  assign z_q = z_r;

endmodule

### hdl/ackermann_go_to_goal_top.sv
// Top level of the Ackermann go-to-goal controller.
`timescale 1ns / 1ps
// Usage:
// The in_ channel carries one control tick per request: vehicle pose and an
// optional new goal. The out_ channel returns exactly one command per tick.
// The cfg_ port is an APB-style register port; write it only while idle.
// Each tick runs a CORDIC vectoring sequence on one shared rotate unit,
// one micro-rotation per cycle, followed by a multiply and post steps.
// A tick passes through the states PRE, the ITER loop over the CORDIC steps,
// MAG, POST, SCALE and OUT before out_tvalid is raised. A tick without an
// active goal takes the same path.
// in_tready is high only when no tick is in progress and the output
// register is empty, so one tick is handled at a time.
// When the receiver stalls, the result holds in the output register and no
// new tick is accepted until it is taken.
// Synchronous active-low reset restores the register defaults, clears the
// stored goal and empties the output register.
module ackermann_go_to_goal_top
  import aggtg_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x[23:0], pos_y[47:24], heading[63:48], goal_new[64],
  // goal_x[88:65], goal_y[112:89], zero fill to 120
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // cmd_valid[0], speed[16:1], steer[32:17], arrived[33], zero fill to 40
  output logic [39:0]  out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int NSteps = (CORDIC_STEPS < AtanEntries) ? CORDIC_STEPS : AtanEntries;
  localparam logic [4:0] LastIter = 5'(NSteps - 1);

  state_t state_r, state_nxt;
  logic [4:0] iter_r, iter_nxt;
  cordic_ctl_t ctl;

  logic [15:0] tol_r;
  logic [14:0] maxspd_r, minspd_r, maxst_r;
  logic signed [23:0] tx_r, ty_r;
  logic active_r;
  logic signed [23:0] px_r, py_r;
  logic signed [15:0] hd_r;
  logic signed [24:0] dx, dy;
  logic signed [27:0] cx;
  logic signed [31:0] cz;
  logic [26:0] dist_r;
  logic signed [17:0] b_r;
  logic rev_r;
  logic [15:0] mag_r;
  logic out_v_r;
  logic [39:0] out_d_r;
  logic cfg_wr;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= 16'd410;
      maxspd_r <= 15'd6144;
      minspd_r <= 15'd901;
      maxst_r <= 15'd4096;
    end else if (cfg_wr && cfg_paddr[1:0] == 2'b00) begin
      case (cfg_paddr[3:2])
        RegGoalTol:  tol_r <= cfg_pwdata[15:0];
        RegMaxSpeed: maxspd_r <= cfg_pwdata[14:0];
        RegMinSpeed: minspd_r <= cfg_pwdata[14:0];
        RegMaxSteer: maxst_r <= cfg_pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      RegGoalTol:  cfg_prdata = {16'd0, tol_r};
      RegMaxSpeed: cfg_prdata = {17'd0, maxspd_r};
      RegMinSpeed: cfg_prdata = {17'd0, minspd_r};
      RegMaxSteer: cfg_prdata = {17'd0, maxst_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // sequencer
  logic accept;
  assign in_tready = (state_r == ST_IDLE) && !out_v_r;
  assign accept = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    iter_nxt = iter_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_PRE;
      ST_PRE: begin
        state_nxt = ST_ITER;
        iter_nxt = '0;
      end
      ST_ITER: begin
        iter_nxt = iter_r + 5'd1;
        if (iter_r == LastIter) state_nxt = ST_MAG;
      end
      ST_MAG:   state_nxt = ST_POST;
      ST_POST:  state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.start = (state_r == ST_PRE);
    ctl.step = (state_r == ST_ITER);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iter_r <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r <= iter_nxt;
    end
  end

  assign dx = 25'(tx_r) - 25'(px_r);
  assign dy = 25'(ty_r) - 25'(py_r);

  aggtg_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .iter(iter_r),
    .dx(dx), .dy(dy), .x_q(cx), .z_q(cz)
  );

  // datapath
  logic [43:0] prod;
  logic signed [31:0] zr;
  logic signed [17:0] ang, b0, b1, b2;
  logic [41:0] sprod;
  logic [26:0] sm;
  logic signed [17:0] st;
  logic signed [16:0] spd;
  logic signed [17:0] mst;
  logic reached;
  logic [39:0] out_d_nxt;

  assign prod = 44'(cx[26:0]) * 44'(InvGainQ16) + 44'd32768;
  assign zr = (cz + 32'sd4) >>> 3;
  assign ang = zr[17:0];
  assign sprod = 42'(dist_r) * 42'(maxspd_r);
  assign sm = sprod[38:12];

  always_comb begin
    b0 = ang - 18'(hd_r);
    b1 = b0;
    if (b0 > 18'(PiQ13)) b1 = b0 - TwoPiQ13;
    b2 = b1;
    if (b1 < -18'(PiQ13)) b2 = b1 + TwoPiQ13;
  end

  assign mst = 18'(maxst_r);

  always_comb begin
    st = b_r;
    if (st > mst) st = mst;
    if (st < -mst) st = -mst;
    spd = rev_r ? -17'(mag_r) : 17'(mag_r);
  end

  assign reached = (dist_r <= 27'(tol_r));

  always_comb begin
    out_d_nxt = '0;
    if (active_r) begin
      out_d_nxt[0] = 1'b1;
      if (reached) begin
        out_d_nxt[33] = 1'b1;
      end else begin
        out_d_nxt[16:1] = spd[15:0];
        out_d_nxt[32:17] = st[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_r <= '0;
      ty_r <= '0;
      active_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (state_r == ST_OUT) out_v_r <= 1'b1;
      else if (out_v_r && out_tready) out_v_r <= 1'b0;
      if (accept) begin
        px_r <= in_tdata[23:0];
        py_r <= in_tdata[47:24];
        hd_r <= in_tdata[63:48];
        if (in_tdata[64]) begin
          tx_r <= in_tdata[88:65];
          ty_r <= in_tdata[112:89];
          active_r <= 1'b1;
        end
      end
      if (state_r == ST_MAG) begin
        dist_r <= prod[42:16];
        b_r <= b2;
      end
      if (state_r == ST_POST) begin
        rev_r <= (b_r > 18'(HalfPiQ13)) || (b_r < -18'(HalfPiQ13));
        if (b_r > 18'(HalfPiQ13)) b_r <= 18'(PiQ13) - b_r;
        else if (b_r < -18'(HalfPiQ13)) b_r <= -18'(PiQ13) - b_r;
      end
      if (state_r == ST_SCALE) begin
        if (dist_r >= 27'(OneMetreQ12)) mag_r <= 16'(maxspd_r);
        else if (sm < 27'(minspd_r)) mag_r <= 16'(minspd_r);
        else mag_r <= sm[15:0];
      end
      if (state_r == ST_OUT) begin
        out_d_r <= out_d_nxt;
        if (active_r && reached) active_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = out_d_r;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == ST_IDLE)
    else $error("ready outside idle");
  a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == ST_OUT)
    else $error("result without sequence");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("accept while result pending");
`endif

endmodule
